// ===== sv/wlfu_pkg.sv =====
// ----------------------------------------------------------------------------
// wlfu_pkg
// Shared types and constants of the windowed LFU page migrator.
// ----------------------------------------------------------------------------
package wlfu_pkg;

    localparam int PAGE_W = 52;
    localparam int CNT_W  = 32;
    localparam int TIME_W = 40;
    localparam int TOT_W  = 64;
    localparam int VAL_W  = 48;
    localparam int WIN_W  = 32;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ACCESS = 2'd1;
    localparam logic [1:0] KIND_MARK   = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CNT_FULL = 2'd1;
    localparam logic [1:0] STAT_RES_FULL = 2'd2;
    localparam logic [1:0] STAT_DUP      = 2'd3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  access_count;
        logic [TIME_W-1:0] time_ms;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [TOT_W-1:0]  hit_total;
        logic [TOT_W-1:0]  miss_total;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic              promoted_valid;
        logic [PAGE_W-1:0] promo_page;
        logic [1:0]        status;
    } t_out_word;

    typedef struct packed {
        logic is_load;
        logic is_access;
        logic is_mark;
    } t_cls;

    typedef struct packed {
        t_cls     cls;
        t_in_word item;
    } t_q_word;

    typedef struct packed {
        logic    valid;
        t_q_word word;
    } t_q_side;

endpackage

// ===== sv/wlfu_front.sv =====
// ----------------------------------------------------------------------------
// wlfu_front
// Accepts input words, decodes the kind and queues them for the back end.
// ----------------------------------------------------------------------------
module wlfu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  wlfu_pkg::t_in_word i_word,
    output wlfu_pkg::t_q_side o_q,
    input  logic              i_pop
);
    import wlfu_pkg::*;

    localparam int DEPTH = 4;

    t_q_word    r_mem [DEPTH];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;
    t_q_word    w_new;

    assign o_stall = (r_cnt == 3'(DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != 3'd0);

    always_comb begin
        w_new.item          = i_word;
        w_new.cls.is_load   = (i_word.kind == KIND_LOAD);
        w_new.cls.is_access = (i_word.kind == KIND_ACCESS);
        w_new.cls.is_mark   = (i_word.kind == KIND_MARK);
    end

    always_comb begin
        n_wp  = push ? r_wp + 2'd1 : r_wp;
        n_rp  = pop ? r_rp + 2'd1 : r_rp;
        n_cnt = r_cnt + 3'(push) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_q.valid = (r_cnt != 3'd0);
    assign o_q.word  = r_mem[r_rp];

endmodule

// ===== sv/wlfu_back.sv =====
// ----------------------------------------------------------------------------
// wlfu_back
// Sequencer that walks the resident and count tables as each queued word needs,
// runs window migrations and drives the registered result word.
// ----------------------------------------------------------------------------
module wlfu_back #(
    parameter int RESIDENT_SLOTS = 64,
    parameter int COUNT_SLOTS    = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wlfu_pkg::t_q_side     i_q,
    output logic                  o_pop,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    output logic                  o_valid,
    input  logic                  i_stall,
    output wlfu_pkg::t_out_word   o_word
);
    import wlfu_pkg::*;

    localparam int RW = (RESIDENT_SLOTS > 1) ? $clog2(RESIDENT_SLOTS) : 1;
    localparam int CW = $clog2(COUNT_SLOTS);
    localparam logic [RW-1:0] RLAST = RW'(RESIDENT_SLOTS - 1);
    localparam logic [CW-1:0] CLAST = CW'(COUNT_SLOTS - 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_LD   = 12'b000000000010,
        S_EV_R = 12'b000000000100,
        S_EV_C = 12'b000000001000,
        S_EV_E = 12'b000000010000,
        S_PR_C = 12'b000000100000,
        S_PR_R = 12'b000001000000,
        S_PR_F = 12'b000010000000,
        S_AC_R = 12'b000100000000,
        S_AC_C = 12'b001000000000,
        S_AC_U = 12'b010000000000,
        S_DONE = 12'b100000000000
    } t_state;

    logic [PAGE_W-1:0] rpage [RESIDENT_SLOTS];
    logic [PAGE_W-1:0] cpage [COUNT_SLOTS];
    logic [VAL_W-1:0]  cval  [COUNT_SLOTS];
    logic [PAGE_W-1:0] r_rd_rp;
    logic [PAGE_W-1:0] r_rd_cp;
    logic [VAL_W-1:0]  r_rd_cv;

    logic [RESIDENT_SLOTS-1:0] r_rv;
    logic [COUNT_SLOTS-1:0]    r_cv;

    t_state            r_st, n_st;
    logic              r_ph, n_ph;
    logic [RW-1:0]     r_ri, n_ri;
    logic [CW-1:0]     r_ci, n_ci;
    t_in_word          r_item, n_item;
    t_cls              r_cls, n_cls;
    logic [WIN_W-1:0]  r_win;
    logic [TIME_W-1:0] r_ws, n_ws;
    logic              r_started, n_started;
    logic [TOT_W-1:0]  r_hits, n_hits;
    logic [TOT_W-1:0]  r_miss, n_miss;
    logic              r_hit, n_hit;
    logic              r_ev, n_ev;
    logic [PAGE_W-1:0] r_evp, n_evp;
    logic              r_pr, n_pr;
    logic [PAGE_W-1:0] r_prp, n_prp;
    logic [1:0]        r_stat, n_stat;
    logic              r_found, n_found;
    logic              r_ffree, n_ffree;
    logic [RW-1:0]     r_fslot, n_fslot;
    logic [PAGE_W-1:0] r_cur, n_cur;
    logic              r_have, n_have;
    logic [VAL_W-1:0]  r_least, n_least;
    logic              r_vfound, n_vfound;
    logic [RW-1:0]     r_vslot, n_vslot;
    logic [PAGE_W-1:0] r_vpage, n_vpage;
    logic [VAL_W-1:0]  r_cand, n_cand;
    logic [VAL_W-1:0]  r_most, n_most;
    logic              r_bfound, n_bfound;
    logic [PAGE_W-1:0] r_bpage, n_bpage;
    logic              r_cfound, n_cfound;
    logic              r_cfree, n_cfree;
    logic [CW-1:0]     r_cslot, n_cslot;
    logic [VAL_W-1:0]  r_cvq, n_cvq;
    logic              r_ov, n_ov;
    t_out_word         r_out, n_out;

    logic              rp_we;
    logic [RW-1:0]     rp_wa;
    logic [PAGE_W-1:0] rp_wd;
    logic              cp_we;
    logic              cv_we;
    logic [CW-1:0]     c_wa;
    logic [VAL_W-1:0]  cv_wd;
    logic              rv_set, rv_clr;
    logic [RW-1:0]     rv_idx;
    logic              cv_set, cv_clr_all;

    logic [TIME_W-1:0] q_t;
    logic [TIME_W-1:0] t_diff;
    logic              migr;
    logic [TOT_W:0]    hsum, msum;
    logic [VAL_W:0]    csum;

    assign q_t    = i_q.word.item.time_ms;
    assign t_diff = q_t - r_ws;
    assign migr   = (q_t > r_ws) && (t_diff > TIME_W'(r_win));
    assign hsum   = {1'b0, r_hits} + (TOT_W+1)'(r_item.access_count);
    assign msum   = {1'b0, r_miss} + (TOT_W+1)'(r_item.access_count);
    assign csum   = {1'b0, r_cvq} + (VAL_W+1)'(r_item.access_count);

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_ri = r_ri; n_ci = r_ci;
        n_item = r_item; n_cls = r_cls; n_ws = r_ws; n_started = r_started;
        n_hits = r_hits; n_miss = r_miss; n_hit = r_hit;
        n_ev = r_ev; n_evp = r_evp; n_pr = r_pr; n_prp = r_prp; n_stat = r_stat;
        n_found = r_found; n_ffree = r_ffree; n_fslot = r_fslot; n_cur = r_cur;
        n_have = r_have; n_least = r_least; n_vfound = r_vfound;
        n_vslot = r_vslot; n_vpage = r_vpage; n_cand = r_cand; n_most = r_most;
        n_bfound = r_bfound; n_bpage = r_bpage; n_cfound = r_cfound;
        n_cfree = r_cfree; n_cslot = r_cslot; n_cvq = r_cvq;
        n_out = r_out;
        n_ov = r_ov & i_stall;
        rp_we = 1'b0; rp_wa = r_ri; rp_wd = r_item.page;
        cp_we = 1'b0; cv_we = 1'b0; c_wa = r_ci; cv_wd = VAL_W'(r_item.access_count);
        rv_set = 1'b0; rv_clr = 1'b0; rv_idx = r_ri;
        cv_set = 1'b0; cv_clr_all = 1'b0;
        o_pop = 1'b0;

        unique case (r_st)
            S_IDLE: begin
                if (i_q.valid) begin
                    o_pop = 1'b1;
                    n_item = i_q.word.item; n_cls = i_q.word.cls;
                    n_hit = 1'b0; n_ev = 1'b0; n_evp = '0; n_pr = 1'b0; n_prp = '0;
                    n_stat = STAT_OK; n_ri = '0; n_ci = '0; n_ph = 1'b0;
                    n_found = 1'b0; n_ffree = 1'b0; n_have = 1'b0; n_vfound = 1'b0;
                    n_bfound = 1'b0; n_most = '0; n_cfound = 1'b0; n_cfree = 1'b0;
                    if (i_q.word.cls.is_load) begin
                        n_st = S_LD;
                    end else if (i_q.word.cls.is_access || i_q.word.cls.is_mark) begin
                        if (!r_started) begin
                            n_started = 1'b1;
                            n_ws = q_t;
                            n_st = i_q.word.cls.is_access ? S_AC_R : S_DONE;
                        end else if (migr) begin
                            n_st = S_EV_R;
                        end else begin
                            n_st = i_q.word.cls.is_access ? S_AC_R : S_DONE;
                        end
                    end else begin
                        n_st = S_DONE;
                    end
                end
            end
            S_LD: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_rv[r_ri] && r_rd_rp == r_item.page) begin
                        n_found = 1'b1;
                    end
                    if (!r_rv[r_ri] && !r_ffree) begin
                        n_ffree = 1'b1;
                        n_fslot = r_ri;
                    end
                    if (r_ri == RLAST) begin
                        n_st = S_DONE;
                        if (n_found) begin
                            n_stat = STAT_DUP;
                        end else if (!n_ffree) begin
                            n_stat = STAT_RES_FULL;
                        end else begin
                            rp_we = 1'b1; rp_wa = n_fslot; rp_wd = r_item.page;
                            rv_set = 1'b1; rv_idx = n_fslot;
                        end
                    end else begin
                        n_ri = r_ri + RW'(1);
                    end
                end
            end
            S_EV_R: begin
                if (!r_ph) begin
                    if (r_rv[r_ri]) begin
                        n_ph = 1'b1;
                    end else if (r_ri == RLAST) begin
                        n_st = S_EV_E;
                    end else begin
                        n_ri = r_ri + RW'(1);
                    end
                end else begin
                    n_ph = 1'b0;
                    n_cur = r_rd_rp;
                    n_ci = '0;
                    n_st = S_EV_C;
                end
            end
            S_EV_C: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_cv[r_ci] && r_rd_cp == r_cur) begin
                        if (!r_have || r_rd_cv < r_least) begin
                            n_have = 1'b1; n_least = r_rd_cv;
                            n_vfound = 1'b1; n_vslot = r_ri; n_vpage = r_cur;
                        end
                        if (r_ri == RLAST) begin
                            n_st = S_EV_E;
                        end else begin
                            n_ri = r_ri + RW'(1);
                            n_st = S_EV_R;
                        end
                    end else if (r_ci == CLAST) begin
                        n_vfound = 1'b1; n_vslot = r_ri; n_vpage = r_cur;
                        n_st = S_EV_E;
                    end else begin
                        n_ci = r_ci + CW'(1);
                    end
                end
            end
            S_EV_E: begin
                if (r_vfound) begin
                    rv_clr = 1'b1; rv_idx = r_vslot;
                    n_ev = 1'b1; n_evp = r_vpage;
                end
                n_ci = '0; n_ph = 1'b0; n_st = S_PR_C;
            end
            S_PR_C: begin
                if (!r_ph && r_cv[r_ci]) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_ph && r_rd_cv > r_most) begin
                        n_cur = r_rd_cp; n_cand = r_rd_cv;
                        n_ri = '0; n_st = S_PR_R;
                    end else if (r_ci == CLAST) begin
                        n_ri = '0; n_st = S_PR_F;
                    end else begin
                        n_ci = r_ci + CW'(1);
                    end
                end
            end
            S_PR_R: begin
                if (!r_ph && r_rv[r_ri]) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_ph && r_rd_rp == r_cur) begin
                        if (r_ci == CLAST) begin
                            n_ri = '0; n_st = S_PR_F;
                        end else begin
                            n_ci = r_ci + CW'(1); n_st = S_PR_C;
                        end
                    end else if (r_ri == RLAST) begin
                        n_most = r_cand; n_bfound = 1'b1; n_bpage = r_cur;
                        if (r_ci == CLAST) begin
                            n_ri = '0; n_st = S_PR_F;
                        end else begin
                            n_ci = r_ci + CW'(1); n_st = S_PR_C;
                        end
                    end else begin
                        n_ri = r_ri + RW'(1);
                    end
                end
            end
            S_PR_F: begin
                if (!r_bfound || !r_rv[r_ri] || r_ri == RLAST) begin
                    if (r_bfound && !r_rv[r_ri]) begin
                        rp_we = 1'b1; rp_wa = r_ri; rp_wd = r_bpage;
                        rv_set = 1'b1; rv_idx = r_ri;
                        n_pr = 1'b1; n_prp = r_bpage;
                    end
                    cv_clr_all = 1'b1;
                    n_ws = r_item.time_ms;
                    n_ri = '0; n_ph = 1'b0;
                    n_st = r_cls.is_access ? S_AC_R : S_DONE;
                end else begin
                    n_ri = r_ri + RW'(1);
                end
            end
            S_AC_R: begin
                if (!r_ph && r_rv[r_ri]) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_ph && r_rd_rp == r_item.page) begin
                        n_hit = 1'b1;
                    end
                    if (r_ri == RLAST) begin
                        n_ci = '0; n_st = S_AC_C;
                    end else begin
                        n_ri = r_ri + RW'(1);
                    end
                end
            end
            S_AC_C: begin
                if (!r_ph && r_cv[r_ci]) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_ph && r_rd_cp == r_item.page) begin
                        n_cfound = 1'b1; n_cslot = r_ci; n_cvq = r_rd_cv;
                        n_st = S_AC_U;
                    end else begin
                        if (!r_ph && !r_cfree) begin
                            n_cfree = 1'b1; n_cslot = r_ci;
                        end
                        if (r_ci == CLAST) begin
                            n_st = S_AC_U;
                        end else begin
                            n_ci = r_ci + CW'(1);
                        end
                    end
                end
            end
            S_AC_U: begin
                if (r_hit) begin
                    n_hits = hsum[TOT_W] ? '1 : hsum[TOT_W-1:0];
                end else begin
                    n_miss = msum[TOT_W] ? '1 : msum[TOT_W-1:0];
                end
                c_wa = r_cslot;
                if (r_cfound) begin
                    cv_we = 1'b1;
                    cv_wd = csum[VAL_W] ? '1 : csum[VAL_W-1:0];
                end else if (r_cfree) begin
                    cp_we = 1'b1; cv_we = 1'b1; cv_set = 1'b1;
                end else begin
                    n_stat = STAT_CNT_FULL;
                end
                n_st = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_out.hit = r_hit;
                    n_out.hit_total = r_hits;
                    n_out.miss_total = r_miss;
                    n_out.evicted_valid = r_ev;
                    n_out.evicted_page = r_evp;
                    n_out.promoted_valid = r_pr;
                    n_out.promo_page = r_prp;
                    n_out.status = r_stat;
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rp_we) begin
            rpage[rp_wa] <= rp_wd;
        end
        r_rd_rp <= rpage[r_ri];
    end

    always_ff @(posedge i_clk) begin
        if (cp_we) begin
            cpage[c_wa] <= r_item.page;
        end
        if (cv_we) begin
            cval[c_wa] <= cv_wd;
        end
        r_rd_cp <= cpage[r_ci];
        r_rd_cv <= cval[r_ci];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
            r_cv <= '0;
        end else begin
            if (rv_set) begin
                r_rv[rv_idx] <= 1'b1;
            end
            if (rv_clr) begin
                r_rv[rv_idx] <= 1'b0;
            end
            if (cv_clr_all) begin
                r_cv <= '0;
            end else if (cv_set) begin
                r_cv[c_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ph <= 1'b0;
            r_win <= WINDOW_RESET;
            r_ws <= '0;
            r_started <= 1'b0;
            r_hits <= '0;
            r_miss <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ph <= n_ph;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            r_ws <= n_ws;
            r_started <= n_started;
            r_hits <= n_hits;
            r_miss <= n_miss;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ri <= n_ri; r_ci <= n_ci; r_item <= n_item; r_cls <= n_cls;
        r_hit <= n_hit; r_ev <= n_ev; r_evp <= n_evp; r_pr <= n_pr; r_prp <= n_prp;
        r_stat <= n_stat; r_found <= n_found; r_ffree <= n_ffree; r_fslot <= n_fslot;
        r_cur <= n_cur; r_have <= n_have; r_least <= n_least; r_vfound <= n_vfound;
        r_vslot <= n_vslot; r_vpage <= n_vpage; r_cand <= n_cand; r_most <= n_most;
        r_bfound <= n_bfound; r_bpage <= n_bpage; r_cfound <= n_cfound;
        r_cfree <= n_cfree; r_cslot <= n_cslot; r_cvq <= n_cvq; r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_word  = r_out;

    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits >= $past(r_hits))
        else $error("hit total decreased");

    a_rp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rp_we |-> !r_rv[rp_wa])
        else $error("resident write to occupied slot");

    a_cv_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cv_set |-> !r_cv[c_wa])
        else $error("count entry allocated twice");

    a_ev_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_EV_E) |-> ($past(r_st) == S_EV_R || $past(r_st) == S_EV_C))
        else $error("eviction end without scan");

endmodule

// ===== sv/windowed_lfu_page_migrator_unit.sv =====
// A load walks the resident table; an access record walks the resident table
// and then the count table, each through a one-port table read.
// A migration adds nested walks in both eviction and promotion.
// Throughput: one word at a time in the back end; the front queue holds four.
// Reset (synchronous, i_rst_n low): tables empty, totals zero, window 1000 ms.
// ----------------------------------------------------------------------------
// windowed_lfu_page_migrator_unit
// Top level: input queue front end and table-walking back end.
// ----------------------------------------------------------------------------
module windowed_lfu_page_migrator_unit #(
    parameter int RESIDENT_SLOTS = 64,
    parameter int COUNT_SLOTS    = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  wlfu_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output wlfu_pkg::t_out_word o_word,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import wlfu_pkg::*;

    t_q_side q_side;
    logic    q_pop;

    wlfu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_q     (q_side),
        .i_pop   (q_pop)
    );

    wlfu_back #(
        .RESIDENT_SLOTS (RESIDENT_SLOTS),
        .COUNT_SLOTS    (COUNT_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_side),
        .o_pop       (q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

endmodule

// ===== tb/wlfu_checker.sv =====
// ----------------------------------------------------------------------------
// wlfu_checker
// Watches both channels of the page migrator and the config port, predicts
// each result word from accepted input words and compares them in order.
// ----------------------------------------------------------------------------
module wlfu_checker #(
    parameter int RES_N = 64,
    parameter int CNT_N = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  wlfu_pkg::t_in_word  in_word,
    input  logic                out_valid,
    input  logic                out_stall,
    input  wlfu_pkg::t_out_word out_word,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    output int                  fail_count,
    output int                  pending
);
    import wlfu_pkg::*;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    logic [PAGE_W-1:0] res_page [RES_N];
    logic              res_vld  [RES_N];
    logic [PAGE_W-1:0] cnt_page [CNT_N];
    logic [VAL_W-1:0]  cnt_val  [CNT_N];
    logic              cnt_vld  [CNT_N];
    logic [TIME_W-1:0] win_start;
    logic              win_started;
    logic [TOT_W-1:0]  hits, misses;
    logic [WIN_W-1:0]  window;
    t_out_word         result_q[$];
    int                errs = 0;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic int res_find(logic [PAGE_W-1:0] p);
        for (int i = 0; i < RES_N; i++) begin
            if (res_vld[i] && res_page[i] == p) return i;
        end
        return -1;
    endfunction

    function automatic int cnt_find(logic [PAGE_W-1:0] p);
        for (int i = 0; i < CNT_N; i++) begin
            if (cnt_vld[i] && cnt_page[i] == p) return i;
        end
        return -1;
    endfunction

    function automatic int res_free();
        for (int i = 0; i < RES_N; i++) begin
            if (!res_vld[i]) return i;
        end
        return -1;
    endfunction

    function automatic logic [TOT_W-1:0] sat_add(logic [TOT_W-1:0] a,
                                                 logic [CNT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + (TOT_W+1)'(b);
        return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

    function automatic void migrate(ref t_out_word r);
        int victim, best, c, s;
        logic have_least;
        logic [VAL_W-1:0] least, most;
        victim = -1;
        best = -1;
        have_least = 0;
        least = 0;
        most = 0;
        for (int i = 0; i < RES_N; i++) begin
            if (res_vld[i]) begin
                c = cnt_find(res_page[i]);
                if (c < 0) begin
                    victim = i;
                    break;
                end
                if (!have_least || cnt_val[c] < least) begin
                    have_least = 1;
                    least = cnt_val[c];
                    victim = i;
                end
            end
        end
        if (victim >= 0) begin
            res_vld[victim] = 0;
            r.evicted_valid = 1;
            r.evicted_page = res_page[victim];
        end
        for (int i = 0; i < CNT_N; i++) begin
            if (cnt_vld[i] && cnt_val[i] > most && res_find(cnt_page[i]) < 0) begin
                most = cnt_val[i];
                best = i;
            end
        end
        if (best >= 0) begin
            s = res_free();
            if (s >= 0) begin
                res_page[s] = cnt_page[best];
                res_vld[s] = 1;
                r.promoted_valid = 1;
                r.promo_page = cnt_page[best];
            end
        end
        for (int i = 0; i < CNT_N; i++) cnt_vld[i] = 0;
    endfunction

    function automatic t_out_word predict_migration(t_in_word w);
        t_out_word r;
        int c, s, f;
        logic [VAL_W:0] v;
        r = '0;
        r.status = STAT_OK;
        if (w.kind == KIND_LOAD) begin
            if (res_find(w.page) >= 0) begin
                r.status = STAT_DUP;
            end else begin
                s = res_free();
                if (s < 0) begin
                    r.status = STAT_RES_FULL;
                end else begin
                    res_page[s] = w.page;
                    res_vld[s] = 1;
                end
            end
        end else if (w.kind == KIND_ACCESS || w.kind == KIND_MARK) begin
            if (!win_started) begin
                win_started = 1;
                win_start = w.time_ms;
            end else if (w.time_ms > win_start &&
                         (w.time_ms - win_start) > {8'd0, window}) begin
                migrate(r);
                win_start = w.time_ms;
            end
            if (w.kind == KIND_ACCESS) begin
                if (res_find(w.page) >= 0) begin
                    r.hit = 1;
                    hits = sat_add(hits, w.access_count);
                end else begin
                    misses = sat_add(misses, w.access_count);
                end
                c = cnt_find(w.page);
                if (c >= 0) begin
                    v = {1'b0, cnt_val[c]} + (VAL_W+1)'(w.access_count);
                    cnt_val[c] = v[VAL_W] ? VAL_MAX : v[VAL_W-1:0];
                end else begin
                    f = -1;
                    for (int i = 0; i < CNT_N; i++) begin
                        if (!cnt_vld[i]) begin
                            f = i;
                            break;
                        end
                    end
                    if (f < 0) begin
                        r.status = STAT_CNT_FULL;
                    end else begin
                        cnt_vld[f] = 1;
                        cnt_page[f] = w.page;
                        cnt_val[f] = VAL_W'(w.access_count);
                    end
                end
            end
        end
        r.hit_total = hits;
        r.miss_total = misses;
        return r;
    endfunction

    function automatic void cmp(string name, logic [TOT_W-1:0] e, logic [TOT_W-1:0] a);
        if (e !== a) begin
            errs++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, e, a);
        end
    endfunction

    always @(posedge clk) begin
        t_out_word e;
        if (!rst_n) begin
            for (int i = 0; i < RES_N; i++) res_vld[i] = 0;
            for (int i = 0; i < CNT_N; i++) cnt_vld[i] = 0;
            win_start = '0;
            win_started = 0;
            hits = '0;
            misses = '0;
            window = WINDOW_RESET;
            result_q.delete();
        end else begin
            if (cfg_we) window = cfg_wdata;
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected word: expected none, got %h",
                             $time, out_word);
                end else begin
                    e = result_q.pop_front();
                    cmp("hit", TOT_W'(e.hit), TOT_W'(out_word.hit));
                    cmp("hit_total", e.hit_total, out_word.hit_total);
                    cmp("miss_total", e.miss_total, out_word.miss_total);
                    cmp("evicted_valid", TOT_W'(e.evicted_valid),
                        TOT_W'(out_word.evicted_valid));
                    cmp("evicted_page", TOT_W'(e.evicted_page),
                        TOT_W'(out_word.evicted_page));
                    cmp("promoted_valid", TOT_W'(e.promoted_valid),
                        TOT_W'(out_word.promoted_valid));
                    cmp("promo_page", TOT_W'(e.promo_page),
                        TOT_W'(out_word.promo_page));
                    cmp("status", TOT_W'(e.status), TOT_W'(out_word.status));
                end
            end
            if (in_valid && !in_stall) begin
                result_q.insert(result_q.size(), predict_migration(in_word));
            end
        end
        pending <= result_q.size();
        fail_count <= errs;
    end

endmodule

// ===== tb/tb_windowed_lfu_page_migrator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_lfu_page_migrator_unit
// Drives load, access, time mark and unused words with random gaps and output
// stalls across several window settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_windowed_lfu_page_migrator_unit;
    import wlfu_pkg::*;

    localparam int        WDOG_LIMIT = 400000;
    localparam int        HOLD_CYCLES = 4000;
    localparam int        POOL_N = 80;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_in_word    i_word = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_out_word   o_word;
    logic        i_cfg_we = 0;
    logic [31:0] i_cfg_wdata = '0;
    int          fail_count, pending;
    logic        hold_req = 0;
    int          quiet = 0;

    logic [PAGE_W-1:0] pool [POOL_N];
    logic [TIME_W-1:0] tnow = 0;
    logic [WIN_W-1:0]  win = WINDOW_RESET;

    windowed_lfu_page_migrator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_word(i_word),
        .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    wlfu_checker u_chk (
        .clk(i_clk), .rst_n(i_rst_n),
        .in_valid(i_valid), .in_stall(o_stall), .in_word(i_word),
        .out_valid(o_valid), .out_stall(i_stall), .out_word(o_word),
        .cfg_we(i_cfg_we), .cfg_wdata(i_cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send(logic [1:0] k, logic [PAGE_W-1:0] p, logic [CNT_W-1:0] c,
                        logic [TIME_W-1:0] t);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_word <= '{kind: k, page: p, access_count: c, time_ms: t};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        win = v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [PAGE_W-1:0] rand_page();
        return PAGE_W'({$urandom, $urandom});
    endfunction

    task automatic random_word();
        int r;
        logic [1:0] k;
        logic [PAGE_W-1:0] p;
        logic [CNT_W-1:0] c;
        logic [TIME_W-1:0] step;
        r = $urandom_range(0, 99);
        k = (r < 10) ? KIND_LOAD : (r < 80) ? KIND_ACCESS : (r < 95) ? KIND_MARK
                                                        : KIND_UNUSED;
        p = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_N - 1)]
                                          : rand_page();
        r = $urandom_range(0, 9);
        c = (r == 0) ? '1 : (r == 1) ? '0 : $urandom;
        r = $urandom_range(0, 99);
        step = TIME_W'((win / 16 > 1000) ? 1000 : win / 16);
        if (r < 85)      tnow = tnow + TIME_W'($urandom_range(0, 32'(step)));
        else if (r < 95) tnow = tnow + TIME_W'(win) + TIME_W'(1 + $urandom_range(0, 2));
        else if (r < 98) tnow = tnow + TIME_W'($urandom_range(0, win));
        else             tnow = TIME_W'({$urandom, $urandom});
        send(k, p, c, tnow);
    endtask

    initial begin
        logic [WIN_W-1:0] wins [5];
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_N; i++) pool[i] = rand_page();
        wins = '{32'd0, 32'hFFFF_FFFF, 32'd37, WINDOW_RESET, 32'd0};
        wins[4] = $urandom_range(50, 100000);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: first timed word, unused kind, loads, hits, misses, windows
        send(KIND_MARK,   pool[5], 32'd7, 40'd5);
        send(KIND_UNUSED, '1, '1, '1);
        send(KIND_LOAD,   pool[0], '0, '0);
        send(KIND_LOAD,   pool[1], '1, '1);
        send(KIND_LOAD,   pool[0], 32'd3, 40'd9);
        send(KIND_ACCESS, pool[0], '1, 40'd10);
        send(KIND_ACCESS, pool[2], '0, 40'd11);
        send(KIND_ACCESS, pool[1], 32'd1, 40'd20);
        send(KIND_ACCESS, pool[3], 32'd9, 40'd3);
        send(KIND_MARK,   pool[3], '0, 40'd1005);
        send(KIND_MARK,   pool[3], '0, 40'd1006);
        send(KIND_ACCESS, pool[4], 32'd100, 40'd1006);
        send(KIND_ACCESS, pool[4], 32'd50, 40'd1500);
        send(KIND_ACCESS, pool[5], 32'd10, 40'd1600);
        send(KIND_ACCESS, pool[5], 32'd10, 40'd2600);
        send(KIND_MARK,   pool[6], '0, 40'd9000);
        send(KIND_MARK,   '0, '0, '1);
        send(KIND_MARK,   '0, '0, 40'd100);
        tnow = 40'd100;

        for (int ph = 0; ph < 5; ph++) begin
            write_window(wins[ph]);
            if (ph == 1) begin
                // fresh pages within one window fill the count table
                for (int i = 0; i < 300; i++)
                    send(KIND_ACCESS, rand_page(), $urandom, tnow);
            end
            for (int i = 0; i < 330; i++) begin
                if (ph == 0 && i == 100) hold_req = 1;
                random_word();
            end
        end
        drain();
        repeat (700) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("windowed_lfu_page_migrator_unit regression: pass");
        end else begin
            $display("windowed_lfu_page_migrator_unit regression: fail");
        end
        $finish;
    end

    // output side: random stalls per word, and one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 0;
            end else if (o_valid && !i_stall) begin
                n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
                if (n > 0) begin
                    i_stall <= 1;
                    repeat (n) @(posedge i_clk);
                    i_stall <= 0;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet = 0;
            else quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("windowed_lfu_page_migrator_unit regression: fail");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
sv/wlfu_pkg.sv
sv/wlfu_front.sv
sv/wlfu_back.sv
sv/windowed_lfu_page_migrator_unit.sv
tb/wlfu_checker.sv
tb/tb_windowed_lfu_page_migrator_unit.sv
